### rtl/shs_pkg.sv
// Constants and round functions for the SHA-256 stream hasher.
package shs_pkg;

    localparam int BUF_WORDS = 16;
    localparam int BUF_AW    = 4;
    localparam int ROUNDS    = 64;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET    = 6'd56;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

### rtl/sha256_stream_hasher_core.sv
// SHA-256 stream hasher top level: byte intake, padding, compression and digest output.
// A data byte is taken only while idle; bytes are packed into 32-bit words in a 16-word
// block RAM. The byte that completes a 64-byte block starts a compression
// (one round per cycle through a single round datapath, then an add into the
// hash), during which no request is taken. A finish request pushes padding bytes
// until the block boundary (64 - fill bytes, or 128 - fill when the length does not
// fit), compresses each padded block, then presents the eight digest words, one per
// cycle while the sink is ready.
module sha256_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] kind: 0 data byte, 1 finish
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast     // last_word
);
    import shs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } pad_t;

    state_t      state_reg, state_next;
    pad_t        pad_reg, pad_next;
    logic        pad_act_reg, pad_act_next;
    logic [2:0]  len_cnt_reg, len_cnt_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic [31:0] hash_reg [8];
    logic [31:0] hash_next [8];

    logic [63:0] total_reg, total_next;
    logic [23:0] part_reg, part_next;
    logic [31:0] wv_reg [8];
    logic [31:0] wv_next [8];
    logic [31:0] sched_reg [BUF_WORDS];
    logic [31:0] sched_next [BUF_WORDS];

    logic              push_en;
    logic [7:0]        push_byte;
    logic [31:0]       word_new;
    logic              ram_we;
    logic [BUF_AW-1:0] ram_raddr;
    logic [31:0]       ram_rdata;
    logic [31:0]       w_cur;
    logic [31:0]       w_calc;
    logic [31:0]       tmp1;
    logic [31:0]       tmp2;
    logic              in_acc;

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {5'd0, out_idx_reg, hash_reg[out_idx_reg]};
    assign m_tlast  = (out_idx_reg == 3'd7);

    assign word_new  = {part_reg, push_byte};
    assign ram_we    = push_en && (fill_reg[1:0] == 2'b11);
    assign ram_raddr = (state_reg == ST_COMP) ? (rnd_reg[BUF_AW-1:0] + 1'b1) : '0;

    shs_ram #(
        .WIDTH(32),
        .DEPTH(BUF_WORDS)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[5:2]),
        .wdata (word_new),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign w_calc = sched_reg[0] + small_sig0(sched_reg[1]) + sched_reg[9]
                  + small_sig1(sched_reg[14]);
    assign w_cur  = (rnd_reg < 7'd16) ? ram_rdata : w_calc;
    assign tmp1   = wv_reg[7] + big_sig1(wv_reg[4]) + choose(wv_reg[4], wv_reg[5], wv_reg[6])
                  + ROUND_K[rnd_reg[5:0]] + w_cur;
    assign tmp2   = big_sig0(wv_reg[0]) + majority(wv_reg[0], wv_reg[1], wv_reg[2]);

    always_comb
    begin
        state_next   = state_reg;
        pad_next     = pad_reg;
        pad_act_next = pad_act_reg;
        len_cnt_next = len_cnt_reg;
        fill_next    = fill_reg;
        bits_next    = bits_reg;
        rnd_next     = rnd_reg;
        out_idx_next = out_idx_reg;
        total_next   = total_reg;
        part_next    = part_reg;
        hash_next    = hash_reg;
        wv_next      = wv_reg;
        sched_next   = sched_reg;
        push_en      = 1'b0;
        push_byte    = s_tdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !s_tuser)
                begin
                    push_en   = 1'b1;
                    bits_next = bits_reg + 64'd8;
                end
                else if (in_acc)
                begin
                    total_next   = bits_reg;
                    pad_act_next = 1'b1;
                    pad_next     = PAD_MARK;
                    len_cnt_next = 3'd0;
                    state_next   = ST_PAD;
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                case (pad_reg)
                    PAD_MARK: push_byte = PAD_MARK_BYTE;
                    PAD_ZERO: push_byte = 8'h00;
                    PAD_LEN:  push_byte = total_reg[{~len_cnt_reg, 3'b111} -: 8];
                    default:  push_byte = 8'h00;
                endcase
                if (pad_reg == PAD_LEN)
                begin
                    len_cnt_next = len_cnt_reg + 3'd1;
                end
                else
                begin
                    pad_next = (fill_reg == LEN_OFFSET - 6'd1) ? PAD_LEN : PAD_ZERO;
                end
            end
            ST_COMP:
            begin
                if (rnd_reg == 7'(ROUNDS))
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_next[i] = hash_reg[i] + wv_reg[i];
                    end
                    if (pad_act_reg && pad_reg == PAD_LEN)
                    begin
                        out_idx_next = 3'd0;
                        state_next   = ST_OUT;
                    end
                    else if (pad_act_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    for (int i = 0; i < BUF_WORDS - 1; i++)
                    begin
                        sched_next[i] = sched_reg[i+1];
                    end
                    sched_next[BUF_WORDS-1] = w_cur;
                    wv_next[7] = wv_reg[6];
                    wv_next[6] = wv_reg[5];
                    wv_next[5] = wv_reg[4];
                    wv_next[4] = wv_reg[3] + tmp1;
                    wv_next[3] = wv_reg[2];
                    wv_next[2] = wv_reg[1];
                    wv_next[1] = wv_reg[0];
                    wv_next[0] = tmp1 + tmp2;
                end
                rnd_next = rnd_reg + 7'd1;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7)
                    begin
                        hash_next    = HASH_IV;
                        fill_next    = 6'd0;
                        bits_next    = 64'd0;
                        pad_act_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_en)
        begin
            part_next = word_new[23:0];
            fill_next = fill_reg + 6'd1;
            if (fill_reg == 6'd63)
            begin
                rnd_next   = 7'd0;
                wv_next    = hash_reg;
                state_next = ST_COMP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pad_reg     <= PAD_MARK;
            pad_act_reg <= 1'b0;
            len_cnt_reg <= 3'd0;
            fill_reg    <= 6'd0;
            bits_reg    <= 64'd0;
            rnd_reg     <= 7'd0;
            out_idx_reg <= 3'd0;
            hash_reg    <= HASH_IV;
        end
        else
        begin
            state_reg   <= state_next;
            pad_reg     <= pad_next;
            pad_act_reg <= pad_act_next;
            len_cnt_reg <= len_cnt_next;
            fill_reg    <= fill_next;
            bits_reg    <= bits_next;
            rnd_reg     <= rnd_next;
            out_idx_reg <= out_idx_next;
            hash_reg    <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        part_reg  <= part_next;
        wv_reg    <= wv_next;
        sched_reg <= sched_next;
    end

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while digest pending");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && fill_reg == 6'd0))
        else $error("not idle after final digest word");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
        else $error("digest word index skipped");

    a_comp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) |-> (rnd_reg <= 7'(ROUNDS)))
        else $error("round counter overran");
`endif

endmodule

### rtl/shs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module shs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### dv/sha256_digest_checker.sv
// Checker for the SHA-256 stream hasher: predicts digests from accepted requests and compares.
`timescale 1ns / 100ps

module sha256_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // [31:0] digest_word, [34:32] word_index, zero fill
    input  logic        m_tlast,    // last_word
    output int          fails,
    output int          words_due
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0]  hash_state [8];
    logic [7:0]   block_bytes [64];
    int           fill;
    logic [63:0]  msg_bits;
    digest_word_t digest_words_due [$];
    int           mismatch_count = 0;

    assign fails = mismatch_count;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int r = 0; r < 16; r++)
            w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
        for (int r = 16; r < 64; r++)
            w[r] = w[r-16] + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
                 + w[r-7] + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
        v = hash_state;
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        block_bytes[fill] = b;
        fill++;
        if (fill == 64)
        begin
            compress_block();
            fill = 0;
        end
    endfunction

    function automatic void restart_message();
        hash_state = START_HASH;
        fill = 0;
        msg_bits = '0;
    endfunction

    function automatic void finish_message();
        logic [63:0]  len;
        digest_word_t d;
        len = msg_bits;
        absorb_byte(8'h80);
        while (fill != 56)
            absorb_byte(8'h00);
        for (int i = 0; i < 8; i++)
            absorb_byte(len[63 - 8*i -: 8]);
        for (int i = 0; i < 8; i++)
        begin
            d.word  = hash_state[i];
            d.index = 3'(i);
            d.last  = (i == 7);
            digest_words_due.push_back(d);
        end
        restart_message();
    endfunction

    task automatic flag(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%t %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_word_t want;
        if (!rst_n)
        begin
            restart_message();
            digest_words_due.delete();
            words_due <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (digest_words_due.size() == 0)
                    flag($sformatf("unexpected digest word: actual word=%h index=%0d last=%b",
                                   m_tdata[31:0], m_tdata[34:32], m_tlast));
                else
                begin
                    want = digest_words_due.pop_front();
                    if (m_tdata[31:0] !== want.word || m_tdata[34:32] !== want.index
                        || m_tlast !== want.last)
                        flag($sformatf({"digest mismatch: expected word=%h index=%0d last=%b,",
                                        " actual word=%h index=%0d last=%b"},
                                       want.word, want.index, want.last,
                                       m_tdata[31:0], m_tdata[34:32], m_tlast));
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                    finish_message();
                else
                begin
                    msg_bits = msg_bits + 64'd8;
                    absorb_byte(s_tdata);
                end
            end
            words_due <= digest_words_due.size();
        end
    end

endmodule

### dv/sha256_stream_hasher_core_test.sv
// Testbench top for the SHA-256 stream hasher: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module sha256_stream_hasher_core_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEM_TARGET    = 370;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int fails;
    int words_due;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    sha256_stream_hasher_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sha256_digest_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .fails     (fails),
        .words_due (words_due)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic kind, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 1'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic set_phase(input int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 8; stall_pct = 8; end
        endcase
    endtask

    initial
    begin
        int len;
        int pick;
        int msg_no;
        msg_no = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty and short messages, finish byte must be ignored
        send_request(1'b1, 8'hff);
        send_request(1'b1, 8'h00);
        send_request(1'b0, 8'h61);
        send_request(1'b0, 8'h62);
        send_request(1'b0, 8'h63);
        send_request(1'b1, 8'h00);
        send_request(1'b0, 8'h00);
        send_request(1'b1, 8'h00);
        send_request(1'b0, 8'hff);
        send_request(1'b1, 8'hff);
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'hff);
        send_request(1'b0, 8'h55);
        send_request(1'b0, 8'haa);
        send_request(1'b1, 8'h5a);

        while (items_sent < ITEM_TARGET)
        begin
            set_phase(msg_no % 4);
            msg_no++;
            pick = $urandom_range(99);
            if (pick < 50)
                len = $urandom_range(12);
            else if (pick < 75)
                len = $urandom_range(72, 50);
            else if (pick < 90)
                len = $urandom_range(49, 13);
            else
                len = $urandom_range(140, 100);
            for (int i = 0; i < len; i++)
                send_request(1'b0, 8'($urandom));
            send_request(1'b1, 8'($urandom));
        end
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (words_due != 0);
        repeat (200) @(posedge clk);

        if (fails == 0 && words_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
